@@ rtl/hrk_pkg.sv @@
// ----------------------------------------------------------------------------
// hrk_pkg
// Shared types, constants and helper functions of the keyboard report differ.
// ----------------------------------------------------------------------------
package hrk_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int NumMods   = 6;
  localparam int NumEvents = NumMods + 2 * KEY_SLOTS;

  localparam logic [9:0] FlagShift = 10'h003;
  localparam logic [9:0] FlagCtrl  = 10'h0C0;
  localparam logic [9:0] FlagAlt   = 10'h300;

  localparam logic [7:0] ScanLctrl  = 8'd224;
  localparam logic [7:0] ScanLshift = 8'd225;
  localparam logic [7:0] ScanLalt   = 8'd226;
  localparam logic [7:0] ScanRctrl  = 8'd228;
  localparam logic [7:0] ScanRshift = 8'd229;
  localparam logic [7:0] ScanRalt   = 8'd230;

  localparam logic [2:0] BitLctrl  = 3'd0;
  localparam logic [2:0] BitLshift = 3'd1;
  localparam logic [2:0] BitLalt   = 3'd2;
  localparam logic [2:0] BitRctrl  = 3'd4;
  localparam logic [2:0] BitRshift = 3'd5;
  localparam logic [2:0] BitRalt   = 3'd6;

  typedef logic [KEY_SLOTS-1:0][7:0] key_arr_t;

  // Everything the serializer needs to emit the events of one report.
  typedef struct packed {
    logic [NumEvents-1:0] mask;
    logic [7:0]           mods;
    key_arr_t             cur;
    key_arr_t             prior;
  } evt_set_t;

  // True for usage codes that have a scancode (identity mapping).
  function automatic logic key_mapped(input logic [7:0] code);
    key_mapped = ((code >= 8'h04) && (code <= 8'h31)) ||
                 ((code >= 8'h33) && (code <= 8'h38)) ||
                 ((code >= 8'h3A) && (code <= 8'h45)) ||
                 ((code >= 8'h4F) && (code <= 8'h52));
  endfunction

  function automatic logic [9:0] flags_of(input logic [7:0] m);
    logic [9:0] f;
    f = '0;
    if ((m & 8'h22) != 8'h00) f = f | FlagShift;
    if ((m & 8'h11) != 8'h00) f = f | FlagCtrl;
    if ((m & 8'h44) != 8'h00) f = f | FlagAlt;
    flags_of = f;
  endfunction

  // Bit position in the modifier byte of modifier event number idx.
  function automatic logic [2:0] mod_pos(input int idx);
    logic [2:0] p;
    case (idx)
      0:       p = BitLctrl;
      1:       p = BitLshift;
      2:       p = BitLalt;
      3:       p = BitRctrl;
      4:       p = BitRshift;
      default: p = BitRalt;
    endcase
    mod_pos = p;
  endfunction

  function automatic logic [7:0] mod_scan(input int idx);
    logic [7:0] s;
    case (idx)
      0:       s = ScanLctrl;
      1:       s = ScanLshift;
      2:       s = ScanLalt;
      3:       s = ScanRctrl;
      4:       s = ScanRshift;
      default: s = ScanRalt;
    endcase
    mod_scan = s;
  endfunction

endpackage

@@ rtl/hid_report_key_event_differ.sv @@
// ----------------------------------------------------------------------------
// hid_report_key_event_differ
// Turns boot keyboard reports into a stream of key press and release events.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   report   in         in_valid_i / in_ready_o   modifier_byte_i, key_slot_*_i
//   event    out        out_valid_o / out_ready_i is_press_o, scan_code_o,
//                                                 mod_flags_o, last_event_o
//
// A report request is captured in an input register. There it is compared with the stored
// report, and its event set loads into the serializer once that is ready; the serializer
// issues one event per cycle into the output register while the output is not stalled.
// A report has at most eighteen events, and one with none issues nothing. A waiting
// report loads in the cycle the last event of the previous one is issued. Reset clears
// the stored report; a stalled output holds the event and backs up the input.
//
module hid_report_key_event_differ import hrk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] modifier_byte_i,
  input  logic [7:0] key_slot_0_i,
  input  logic [7:0] key_slot_1_i,
  input  logic [7:0] key_slot_2_i,
  input  logic [7:0] key_slot_3_i,
  input  logic [7:0] key_slot_4_i,
  input  logic [7:0] key_slot_5_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_press_o,
  output logic [7:0] scan_code_o,
  output logic [9:0] mod_flags_o,
  output logic       last_event_o
);

  logic                 in_valid_q;
  logic [7:0]           mods_q;
  key_arr_t             keys_q;
  logic [7:0]           prior_mods_q;
  key_arr_t             prior_keys_q;
  logic                 load_ready;
  logic                 load;
  logic [NumEvents-1:0] mask;
  evt_set_t             load_set;

  // The input register is free when empty or when its report moves on now.
  assign in_ready_o = !in_valid_q || load_ready;
  assign load       = in_valid_q && load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mods_q    <= modifier_byte_i;
      keys_q[0] <= key_slot_0_i;
      keys_q[1] <= key_slot_1_i;
      keys_q[2] <= key_slot_2_i;
      keys_q[3] <= key_slot_3_i;
      keys_q[4] <= key_slot_4_i;
      keys_q[5] <= key_slot_5_i;
    end
  end

  // The stored report advances when a report hands its events over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_mods_q <= '0;
      prior_keys_q <= '0;
    end else if (load) begin
      prior_mods_q <= mods_q;
      prior_keys_q <= keys_q;
    end
  end

  hrk_diff u_diff (
    .mods_i       (mods_q),
    .cur_i        (keys_q),
    .prior_mods_i (prior_mods_q),
    .prior_i      (prior_keys_q),
    .mask_o       (mask)
  );

  assign load_set.mask  = mask;
  assign load_set.mods  = mods_q;
  assign load_set.cur   = keys_q;
  assign load_set.prior = prior_keys_q;

  hrk_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid_q),
    .load_set_i   (load_set),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_press_o   (is_press_o),
    .scan_code_o  (scan_code_o),
    .mod_flags_o  (mod_flags_o),
    .last_event_o (last_event_o)
  );

  // Every emitted event carries a real scancode.
  a_scan_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (scan_code_o != 8'h00))
    else $error("event with empty scancode");

  // Events of one report follow one another without gaps once taken.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_event_o) |=> out_valid_o)
    else $error("gap inside the events of one report");

  // A report waiting in the input register is not lost while blocked.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_ready_o) |=> (in_valid_q && $stable(mods_q)))
    else $error("blocked report dropped");

endmodule

@@ rtl/hrk_diff.sv @@
// ----------------------------------------------------------------------------
// hrk_diff
// Compares a report with the stored one and flags every event it causes.
// ----------------------------------------------------------------------------
module hrk_diff import hrk_pkg::*; (
  input  logic [7:0]           mods_i,
  input  key_arr_t             cur_i,
  input  logic [7:0]           prior_mods_i,
  input  key_arr_t             prior_i,
  output logic [NumEvents-1:0] mask_o
);

  logic [7:0]           changed;
  logic [KEY_SLOTS-1:0] cur_in_prior;
  logic [KEY_SLOTS-1:0] prior_in_cur;

  assign changed = mods_i ^ prior_mods_i;

  always_comb begin
    cur_in_prior = '0;
    prior_in_cur = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (cur_i[i] == prior_i[j]) cur_in_prior[i] = 1'b1;
        if (prior_i[i] == cur_i[j]) prior_in_cur[i] = 1'b1;
      end
    end
  end

  // Mapped codes are never zero, so empty slots drop out by themselves.
  always_comb begin
    mask_o = '0;
    for (int i = 0; i < NumMods; i++) begin
      mask_o[i] = changed[mod_pos(i)];
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      mask_o[NumMods + i] = key_mapped(cur_i[i]) && !cur_in_prior[i];
      mask_o[NumMods + KEY_SLOTS + i] = key_mapped(prior_i[i]) && !prior_in_cur[i];
    end
  end

endmodule

@@ rtl/hrk_serializer.sv @@
// ----------------------------------------------------------------------------
// hrk_serializer
// Holds the event set of one report and, while the output is not stalled,
// emits one event per cycle into the output register, in mask order.
// ----------------------------------------------------------------------------
module hrk_serializer import hrk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_valid_i,
  input  evt_set_t   load_set_i,
  output logic       load_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_press_o,
  output logic [7:0] scan_code_o,
  output logic [9:0] mod_flags_o,
  output logic       last_event_o
);

  logic [NumEvents-1:0] mask_q, mask_d;
  logic [NumEvents-1:0] pick, rest;
  logic [7:0]           mods_q;
  key_arr_t             cur_q, prior_q;
  logic                 out_valid_q, out_valid_d;
  logic                 is_press_q, last_q;
  logic [7:0]           scan_q;
  logic [9:0]           flags_q;
  logic                 out_free, has_evt, fire, load;
  logic                 sel_press;
  logic [7:0]           sel_scan;

  assign out_free     = !out_valid_q || out_ready_i;
  assign has_evt      = |mask_q;
  assign pick         = mask_q & (~mask_q + {{(NumEvents-1){1'b0}}, 1'b1});
  assign rest         = mask_q & ~pick;
  assign fire         = out_free && has_evt;
  assign load_ready_o = !has_evt || (fire && (rest == '0));
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    sel_press = 1'b0;
    sel_scan  = '0;
    for (int i = 0; i < NumMods; i++) begin
      if (pick[i]) begin
        sel_press = sel_press | mods_q[mod_pos(i)];
        sel_scan  = sel_scan | mod_scan(i);
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (pick[NumMods + i]) begin
        sel_press = 1'b1;
        sel_scan  = sel_scan | cur_q[i];
      end
      if (pick[NumMods + KEY_SLOTS + i]) begin
        sel_scan = sel_scan | prior_q[i];
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = load_set_i.mask;
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mods_q  <= load_set_i.mods;
      cur_q   <= load_set_i.cur;
      prior_q <= load_set_i.prior;
    end
    if (fire) begin
      is_press_q <= sel_press;
      scan_q     <= sel_scan;
      flags_q    <= flags_of(mods_q);
      last_q     <= (rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_press_o   = is_press_q;
  assign scan_code_o  = scan_q;
  assign mod_flags_o  = flags_q;
  assign last_event_o = last_q;

endmodule
